// File: hdl/afc_pkg.sv
// Shared types, constants and lookup functions of the autoranging frequency counter.
package afc_pkg;

  // Default width of the edge counter.
  localparam int unsigned COUNTER_BITS_DEF = 16;

  // Widths fixed by the interface.
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned FREQ_W    = 26;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned GATE_W    = 2;
  localparam int unsigned MS_W      = 10;
  localparam int unsigned MULT_W    = 10;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes (byte address / 4).
  localparam logic [1:0] REG_COUNT_EDGE = 2'd0;
  localparam logic [1:0] REG_HIGH_LIMIT = 2'd1;
  localparam logic [1:0] REG_LOW_LIMIT  = 2'd2;

  // Register reset values.
  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = 16'd65400;
  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = 16'd100;

  // Gate ranges.
  localparam logic [GATE_W-1:0] GATE_1MS    = 2'd0;
  localparam logic [GATE_W-1:0] GATE_10MS   = 2'd1;
  localparam logic [GATE_W-1:0] GATE_100MS  = 2'd2;
  localparam logic [GATE_W-1:0] GATE_1000MS = 2'd3;
  localparam logic [GATE_W-1:0] GATE_RST    = GATE_100MS;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_VALID      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SIGNAL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LOW    = 2'd3;

  typedef struct packed {
    logic sig_level;
    logic ms_tick;
    logic start_req;
  } sample_t;

  typedef struct packed {
    logic               count_edge;
    logic [LIMIT_W-1:0] high_limit;
    logic [LIMIT_W-1:0] low_limit;
  } cfg_t;

  typedef struct packed {
    logic                rerun;
    logic [GATE_W-1:0]   next_gate;
    logic [STATUS_W-1:0] status;
  } judge_t;

  typedef struct packed {
    logic [FREQ_W-1:0]   freq_hz;
    logic [STATUS_W-1:0] status;
    logic [GATE_W-1:0]   gate_range;
  } result_t;

  // Gate length in milliseconds.
  function automatic logic [MS_W-1:0] gate_ms(input logic [GATE_W-1:0] g);
    logic [MS_W-1:0] ms;
    case (g)
      GATE_1MS:    ms = 10'd1;
      GATE_10MS:   ms = 10'd10;
      GATE_100MS:  ms = 10'd100;
      GATE_1000MS: ms = 10'd1000;
      default:     ms = 10'd1000;
    endcase
    return ms;
  endfunction

  // Factor that turns a count over the gate into Hz.
  function automatic logic [MULT_W-1:0] hz_mult(input logic [GATE_W-1:0] g);
    logic [MULT_W-1:0] m;
    case (g)
      GATE_1MS:    m = 10'd1000;
      GATE_10MS:   m = 10'd100;
      GATE_100MS:  m = 10'd10;
      GATE_1000MS: m = 10'd1;
      default:     m = 10'd1;
    endcase
    return m;
  endfunction

endpackage

// File: hdl/afc_cfg.sv
// APB-style register file holding the edge select and the range limits.
module afc_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [afc_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [afc_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [afc_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready,
  output afc_pkg::cfg_t                        cfg_o
);

  logic                          count_edge_q;
  logic [afc_pkg::LIMIT_W-1:0]   high_limit_q;
  logic [afc_pkg::LIMIT_W-1:0]   low_limit_q;
  logic                          wr_en;
  logic [1:0]                    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_edge_q <= 1'b0;
      high_limit_q <= afc_pkg::HIGH_LIMIT_RST;
      low_limit_q  <= afc_pkg::LOW_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        afc_pkg::REG_COUNT_EDGE: count_edge_q <= pwdata[0];
        afc_pkg::REG_HIGH_LIMIT: high_limit_q <= pwdata[afc_pkg::LIMIT_W-1:0];
        afc_pkg::REG_LOW_LIMIT:  low_limit_q  <= pwdata[afc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      afc_pkg::REG_COUNT_EDGE: prdata = {31'd0, count_edge_q};
      afc_pkg::REG_HIGH_LIMIT: prdata = {16'd0, high_limit_q};
      afc_pkg::REG_LOW_LIMIT:  prdata = {16'd0, low_limit_q};
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o.count_edge = count_edge_q;
  assign cfg_o.high_limit = high_limit_q;
  assign cfg_o.low_limit  = low_limit_q;

endmodule

// File: hdl/afc_judge.sv
// Gate-end decision: range change, error status or scaled frequency.
module afc_judge #(
  parameter int unsigned COUNTER_BITS = afc_pkg::COUNTER_BITS_DEF
) (
  input  logic [COUNTER_BITS-1:0]        count_i,
  input  logic                           overflow_i,
  input  logic [afc_pkg::GATE_W-1:0]     gate_i,
  input  afc_pkg::cfg_t                  cfg_i,
  output afc_pkg::judge_t                judge_o,
  output logic [afc_pkg::FREQ_W-1:0]     freq_o
);

  localparam int unsigned CW = (COUNTER_BITS > afc_pkg::LIMIT_W) ? COUNTER_BITS
                                                                 : afc_pkg::LIMIT_W;

  logic [CW-1:0] count_ext;
  logic          over;
  logic          under;

  assign count_ext = CW'(count_i);
  assign over      = overflow_i | (count_ext > CW'(cfg_i.high_limit));
  assign under     = count_ext < CW'(cfg_i.low_limit);

  always_comb begin
    judge_o.rerun     = 1'b0;
    judge_o.next_gate = gate_i;
    judge_o.status    = afc_pkg::ST_VALID;
    if (over) begin
      if (gate_i == afc_pkg::GATE_1MS) begin
        judge_o.status = afc_pkg::ST_OVER_RANGE;
      end else begin
        judge_o.rerun     = 1'b1;
        judge_o.next_gate = gate_i - afc_pkg::GATE_W'(1);
      end
    end else if (under) begin
      if (gate_i == afc_pkg::GATE_1000MS) begin
        judge_o.status = (count_ext == '0) ? afc_pkg::ST_NO_SIGNAL : afc_pkg::ST_TOO_LOW;
      end else begin
        judge_o.rerun     = 1'b1;
        judge_o.next_gate = gate_i + afc_pkg::GATE_W'(1);
      end
    end
  end

  // A valid count never exceeds the 16-bit high limit, so the low bits carry it all.
  always_comb begin
    if (!over && !under) begin
      freq_o = afc_pkg::FREQ_W'(count_ext[afc_pkg::LIMIT_W-1:0])
             * afc_pkg::FREQ_W'(afc_pkg::hz_mult(gate_i));
    end else begin
      freq_o = '0;
    end
  end

endmodule

// File: hdl/afc_core.sv
// Measurement state: edge counter, millisecond timer, gate range and busy flag.
module afc_core #(
  parameter int unsigned COUNTER_BITS = afc_pkg::COUNTER_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  afc_pkg::sample_t  sample_i,
  input  afc_pkg::cfg_t     cfg_i,
  output logic              res_valid_o,
  output afc_pkg::result_t  res_o
);

  logic                          prev_q, prev_d;
  logic [COUNTER_BITS-1:0]       cnt_q, cnt_d, cnt_inc;
  logic                          ovf_q, ovf_d, ovf_inc;
  logic [afc_pkg::MS_W-1:0]      ms_q, ms_d, ms_inc;
  logic [afc_pkg::GATE_W-1:0]    gate_q, gate_d;
  logic                          busy_q, busy_d;
  logic                          edge_hit;
  logic                          rerun_hit;
  afc_pkg::judge_t               jdg;
  logic [afc_pkg::FREQ_W-1:0]    freq;

  afc_judge #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_judge (
    .count_i   (cnt_inc),
    .overflow_i(ovf_inc),
    .gate_i    (gate_q),
    .cfg_i     (cfg_i),
    .judge_o   (jdg),
    .freq_o    (freq)
  );

  always_comb begin
    edge_hit = cfg_i.count_edge ? (prev_q & ~sample_i.sig_level)
                                : (~prev_q & sample_i.sig_level);
    cnt_inc = cnt_q;
    ovf_inc = ovf_q;
    if (edge_hit) begin
      if (&cnt_q) begin
        cnt_inc = '0;
        ovf_inc = 1'b1;
      end else begin
        cnt_inc = cnt_q + COUNTER_BITS'(1);
      end
    end
    ms_inc = ms_q + afc_pkg::MS_W'(1);
  end

  always_comb begin
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    ms_d        = ms_q;
    gate_d      = gate_q;
    busy_d      = busy_q;
    res_valid_o = 1'b0;
    rerun_hit   = 1'b0;
    if (fire_i) begin
      prev_d = sample_i.sig_level;
      if (!busy_q) begin
        if (sample_i.start_req) begin
          busy_d = 1'b1;
          cnt_d  = '0;
          ovf_d  = 1'b0;
          ms_d   = '0;
        end
      end else begin
        cnt_d = cnt_inc;
        ovf_d = ovf_inc;
        if (sample_i.ms_tick) begin
          ms_d = ms_inc;
          if (ms_inc >= afc_pkg::gate_ms(gate_q)) begin
            if (jdg.rerun) begin
              // The range moved: measure again at the new gate.
              rerun_hit = 1'b1;
              gate_d    = jdg.next_gate;
              cnt_d     = '0;
              ovf_d     = 1'b0;
              ms_d      = '0;
            end else begin
              busy_d      = 1'b0;
              res_valid_o = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      ms_q   <= '0;
      gate_q <= afc_pkg::GATE_RST;
      busy_q <= 1'b0;
    end else begin
      prev_q <= prev_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      ms_q   <= ms_d;
      gate_q <= gate_d;
      busy_q <= busy_d;
    end
  end

  assign res_o.freq_hz    = freq;
  assign res_o.status     = jdg.status;
  assign res_o.gate_range = gate_q;

  a_res_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy_q)
    else $error("result produced while no measurement was running");

  a_res_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !busy_q)
    else $error("measurement still running after its result");

  a_gate_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |=> $stable(gate_q))
    else $error("gate range moved while idle");

  a_rerun_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rerun_hit |=> (busy_q && cnt_q == '0 && ms_q == '0 && !ovf_q))
    else $error("range change did not restart the measurement");

endmodule

// File: hdl/autorange_frequency_counter.sv
// Top level of the autoranging gated frequency counter: sample and result registers.
// The block takes one sample (signal level, ms tick, start request) every clock cycle
// while in_stall_o is low; in_stall_o rises only when a finished result waits in the
// output register under out_stall_i. A sample is registered on acceptance and folded
// into the measurement state when it leaves the sample register; the result of the
// sample that ends its gate is registered in the output register for out_valid_o. One
// measurement yields at most one result, after 1 to 1000 ms of ticks per gate. Each
// range change reruns the measurement at the new gate, and changes go on until a count
// lands between the limits or the range runs out at 1 ms or 1000 ms, so limits set
// close together can keep the gate moving with no end; the gate range is kept between
// measurements.
module autorange_frequency_counter #(
  parameter int unsigned COUNTER_BITS = afc_pkg::COUNTER_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 sig_level_i,
  input  logic                                 ms_tick_i,
  input  logic                                 start_req_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [afc_pkg::FREQ_W-1:0]           freq_hz_o,
  output logic [afc_pkg::STATUS_W-1:0]         status_o,
  output logic [afc_pkg::GATE_W-1:0]           gate_range_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [afc_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [afc_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [afc_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  afc_pkg::cfg_t     cfg;
  afc_pkg::sample_t  smp_q;
  logic              smp_valid_q, smp_valid_d;
  logic              advance;
  logic              in_accept;
  logic              res_valid;
  afc_pkg::result_t  res;
  afc_pkg::result_t  out_q;
  logic              out_valid_q, out_valid_d;

  afc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // The held sample moves on whenever the result slot is free or being emptied.
  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = smp_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    smp_valid_d = smp_valid_q;
    if (in_accept) begin
      smp_valid_d = 1'b1;
    end else if (advance) begin
      smp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
    end else begin
      smp_valid_q <= smp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      smp_q.sig_level <= sig_level_i;
      smp_q.ms_tick   <= ms_tick_i;
      smp_q.start_req <= start_req_i;
    end
  end

  afc_core #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (smp_valid_q && advance),
    .sample_i   (smp_q),
    .cfg_i      (cfg),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign freq_hz_o    = out_q.freq_hz;
  assign status_o     = out_q.status;
  assign gate_range_o = out_q.gate_range;

endmodule

// File: test/tb_autorange_frequency_counter.sv
// Self-checking testbench for the autoranging gated frequency counter.
`timescale 1ns / 1ps

module tb_autorange_frequency_counter;

  localparam int unsigned CNT_W          = afc_pkg::COUNTER_BITS_DEF;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RANDOM_SAMPLES = 420;
  localparam int unsigned MEAS_CAP       = 150;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic                           sig_level_i;
  logic                           ms_tick_i;
  logic                           start_req_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [afc_pkg::FREQ_W-1:0]     freq_hz_o;
  logic [afc_pkg::STATUS_W-1:0]   status_o;
  logic [afc_pkg::GATE_W-1:0]     gate_range_o;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [afc_pkg::CFG_ADDR_W-1:0] paddr;
  logic [afc_pkg::CFG_DATA_W-1:0] pwdata;
  logic [afc_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  autorange_frequency_counter #(
    .COUNTER_BITS(CNT_W)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sig_level_i (sig_level_i),
    .ms_tick_i   (ms_tick_i),
    .start_req_i (start_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .freq_hz_o   (freq_hz_o),
    .status_o    (status_o),
    .gate_range_o(gate_range_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Predicted counter state and register copies.
  logic                        last_level;
  logic [CNT_W-1:0]            edge_cnt;
  logic                        cnt_wrapped;
  logic [afc_pkg::MS_W-1:0]    ms_count;
  logic [afc_pkg::GATE_W-1:0]  gate_sel;
  logic                        measuring;
  logic                        cfg_falling;
  logic [afc_pkg::LIMIT_W-1:0] cfg_high;
  logic [afc_pkg::LIMIT_W-1:0] cfg_low;
  afc_pkg::result_t            pending_results[$];

  int unsigned mismatches;
  int unsigned n_samples;
  int unsigned stuck_cycles;
  int unsigned burst_left;
  int unsigned stall_left;
  bit          stall_on;
  logic        drv_level;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int unsigned gate_len(input logic [afc_pkg::GATE_W-1:0] g);
    case (g)
      afc_pkg::GATE_1MS:   return 1;
      afc_pkg::GATE_10MS:  return 10;
      afc_pkg::GATE_100MS: return 100;
      default:             return 1000;
    endcase
  endfunction

  function automatic void clear_window();
    edge_cnt    = '0;
    cnt_wrapped = 1'b0;
    ms_count    = '0;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch: %s", $time, what);
    end
  endtask

  // Advances the predicted state by one accepted sample beat.
  task automatic fold_sample(input afc_pkg::sample_t s);
    logic                       hit;
    logic [afc_pkg::GATE_W-1:0] g;
    afc_pkg::result_t           res;
    hit = cfg_falling ? (last_level && !s.sig_level) : (!last_level && s.sig_level);
    last_level = s.sig_level;
    if (!measuring) begin
      if (s.start_req) begin
        measuring = 1'b1;
        clear_window();
      end
      return;
    end
    if (hit) begin
      if (&edge_cnt) begin
        edge_cnt    = '0;
        cnt_wrapped = 1'b1;
      end else begin
        edge_cnt = edge_cnt + CNT_W'(1);
      end
    end
    if (!s.ms_tick) return;
    ms_count = ms_count + afc_pkg::MS_W'(1);
    g = gate_sel;
    if (ms_count < gate_len(g)) return;
    res            = '0;
    res.gate_range = g;
    // The high test is done first, so it wins when the limits cross.
    if (cnt_wrapped || edge_cnt > cfg_high) begin
      if (g != afc_pkg::GATE_1MS) begin
        gate_sel = g - afc_pkg::GATE_W'(1);
        clear_window();
        return;
      end
      res.status = afc_pkg::ST_OVER_RANGE;
    end else if (edge_cnt < cfg_low) begin
      if (g != afc_pkg::GATE_1000MS) begin
        gate_sel = g + afc_pkg::GATE_W'(1);
        clear_window();
        return;
      end
      res.status = (edge_cnt == '0) ? afc_pkg::ST_NO_SIGNAL : afc_pkg::ST_TOO_LOW;
    end else begin
      res.status  = afc_pkg::ST_VALID;
      res.freq_hz = afc_pkg::FREQ_W'(edge_cnt * (1000 / gate_len(g)));
    end
    measuring = 1'b0;
    pending_results.push_back(res);
  endtask

  always @(posedge clk_i) begin
    afc_pkg::sample_t smp;
    afc_pkg::result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        smp.sig_level = sig_level_i;
        smp.ms_tick   = ms_tick_i;
        smp.start_req = start_req_i;
        n_samples++;
        fold_sample(smp);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result freq=%0d status=%0d gate=%0d",
                                    freq_hz_o, status_o, gate_range_o));
        end else begin
          want = pending_results.pop_front();
          if (freq_hz_o !== want.freq_hz) begin
            report_mismatch($sformatf("freq_hz expected %0d got %0d",
                                      want.freq_hz, freq_hz_o));
          end
          if (status_o !== want.status) begin
            report_mismatch($sformatf("status expected %0d got %0d", want.status, status_o));
          end
          if (gate_range_o !== want.gate_range) begin
            report_mismatch($sformatf("gate_range expected %0d got %0d",
                                      want.gate_range, gate_range_o));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= WATCHDOG_LIMIT);
    $display("tb_autorange_frequency_counter failed");
    $finish;
  end

  // Result-side back-pressure: short stalls between runs of free flow, some of them long.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_on = !stall_on;
      if (stall_on) begin
        stall_left = $urandom_range(12, 1);
      end else begin
        stall_left = ($urandom_range(3) == 0) ? $urandom_range(200, 40) : $urandom_range(15, 1);
      end
    end else begin
      stall_left--;
    end
    out_stall_i <= stall_on;
  end

  // Drives one sample beat and returns at the falling edge after it was taken.
  task automatic send_sample(input logic lvl, input logic tick, input logic start);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(300, 100) : $urandom_range(16, 1);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    sig_level_i <= lvl;
    ms_tick_i   <= tick;
    start_req_i <= start;
    drv_level = lvl;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
  endtask

  task automatic send_samples(input int unsigned n, input int unsigned toggle_pct,
                              input int unsigned tick_pct, input int unsigned start_pct);
    repeat (n) begin
      send_sample(chance(toggle_pct) ? ~drv_level : drv_level, chance(tick_pct),
                  chance(start_pct));
    end
  endtask

  // Feeds random samples while a measurement runs; stray start requests are mixed in.
  task automatic run_until_idle(input int unsigned toggle_pct, input int unsigned tick_pct,
                                input int unsigned cap);
    int unsigned k;
    k = 0;
    while (measuring && k < cap) begin
      send_sample(chance(toggle_pct) ? ~drv_level : drv_level, chance(tick_pct), chance(15));
      k++;
    end
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic access_reg(input bit wr, input logic [1:0] idx,
                            input logic [afc_pkg::CFG_DATA_W-1:0] data);
    logic [afc_pkg::CFG_DATA_W-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (wr) begin
      case (idx)
        afc_pkg::REG_COUNT_EDGE: cfg_falling = data[0];
        afc_pkg::REG_HIGH_LIMIT: cfg_high = data[afc_pkg::LIMIT_W-1:0];
        afc_pkg::REG_LOW_LIMIT:  cfg_low = data[afc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end else begin
      case (idx)
        afc_pkg::REG_COUNT_EDGE: want = afc_pkg::CFG_DATA_W'(cfg_falling);
        afc_pkg::REG_HIGH_LIMIT: want = afc_pkg::CFG_DATA_W'(cfg_high);
        afc_pkg::REG_LOW_LIMIT:  want = afc_pkg::CFG_DATA_W'(cfg_low);
        default:                 want = '0;
      endcase
      if (prdata !== want) begin
        report_mismatch($sformatf("register %0d read expected %0d got %0d", idx, want, prdata));
      end
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic falling, input logic [afc_pkg::LIMIT_W-1:0] hi,
                            input logic [afc_pkg::LIMIT_W-1:0] lo);
    quiesce();
    access_reg(1'b1, afc_pkg::REG_COUNT_EDGE, afc_pkg::CFG_DATA_W'(falling));
    access_reg(1'b0, afc_pkg::REG_COUNT_EDGE, '0);
    access_reg(1'b1, afc_pkg::REG_HIGH_LIMIT, afc_pkg::CFG_DATA_W'(hi));
    access_reg(1'b0, afc_pkg::REG_HIGH_LIMIT, '0);
    access_reg(1'b1, afc_pkg::REG_LOW_LIMIT, afc_pkg::CFG_DATA_W'(lo));
    access_reg(1'b0, afc_pkg::REG_LOW_LIMIT, '0);
  endtask

  task automatic test_register_defaults();
    access_reg(1'b0, afc_pkg::REG_COUNT_EDGE, '0);
    access_reg(1'b0, afc_pkg::REG_HIGH_LIMIT, '0);
    access_reg(1'b0, afc_pkg::REG_LOW_LIMIT, '0);
  endtask

  // Edges and ticks while no measurement is armed must not produce anything.
  task automatic test_idle_samples();
    send_samples(8, 50, 100, 0);
  endtask

  // A zero high limit walks the gate down to 1 ms; an edge-free run there reads valid.
  task automatic test_shrink_to_1ms();
    set_config(1'b0, 16'd0, 16'd0);
    send_sample(drv_level, 1'b0, 1'b1);
    run_until_idle(100, 100, 300);
    send_sample(drv_level, 1'b0, 1'b1);
    run_until_idle(0, 100, 20);
  endtask

  // A count under the low limit at 1 ms widens the gate to 10 ms, where it reads valid.
  task automatic test_widen_gate();
    set_config(1'b0, 16'hFFFF, 16'd3);
    send_sample(drv_level, 1'b0, 1'b1);
    run_until_idle(100, 100, 40);
    set_config(1'b1, 16'hFFFF, 16'd0);
    send_sample(drv_level, 1'b0, 1'b1);
    run_until_idle(60, 100, 40);
  endtask

  // Low limit above high limit: a count between them is both too high and too low.
  task automatic test_crossed_limits();
    set_config(1'b0, 16'd2, 16'd10);
    send_sample(1'b0, 1'b0, 1'b1);
    send_samples(6, 100, 0, 0);
    send_sample(drv_level, 1'b1, 1'b0);
    send_sample(1'b0, 1'b0, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0);
    run_until_idle(50, 40, 300);
  endtask

  task automatic test_random_traffic();
    int unsigned first_smp;
    int unsigned phase_end;
    int unsigned toggle_pct;
    int unsigned tick_pct;
    logic [afc_pkg::LIMIT_W-1:0] hi;
    logic [afc_pkg::LIMIT_W-1:0] lo;
    first_smp = n_samples;
    while (n_samples - first_smp < RANDOM_SAMPLES) begin
      case ($urandom_range(4))
        0: begin
          hi = afc_pkg::LIMIT_W'($urandom_range(6));
          lo = '0;
        end
        1: begin
          hi = afc_pkg::LIMIT_W'($urandom_range(10, 3));
          lo = afc_pkg::LIMIT_W'($urandom_range(2, 1));
        end
        2: begin
          hi = 16'hFFFF;
          lo = '0;
        end
        3: begin
          hi = '0;
          lo = '0;
        end
        default: begin
          hi = afc_pkg::LIMIT_W'($urandom_range(12));
          lo = afc_pkg::LIMIT_W'($urandom_range(6));
        end
      endcase
      set_config(1'($urandom_range(1)), hi, lo);
      toggle_pct = $urandom_range(100, 40);
      tick_pct   = $urandom_range(100, 30);
      phase_end  = n_samples + $urandom_range(150, 40);
      while (n_samples < phase_end) begin
        if (chance(20)) begin
          send_samples($urandom_range(4, 1), 50, 50, 0);
        end else begin
          send_sample(1'($urandom_range(1)), chance(30), 1'b1);
          run_until_idle(toggle_pct, tick_pct, MEAS_CAP);
        end
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sig_level_i = 1'b0;
    ms_tick_i   = 1'b0;
    start_req_i = 1'b0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    drv_level   = 1'b0;
    last_level  = 1'b0;
    edge_cnt    = '0;
    cnt_wrapped = 1'b0;
    ms_count    = '0;
    gate_sel    = afc_pkg::GATE_RST;
    measuring   = 1'b0;
    cfg_falling = 1'b0;
    cfg_high    = afc_pkg::HIGH_LIMIT_RST;
    cfg_low     = afc_pkg::LOW_LIMIT_RST;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_register_defaults();
    test_idle_samples();
    test_shrink_to_1ms();
    test_widen_gate();
    test_crossed_limits();
    test_random_traffic();
    quiesce();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_autorange_frequency_counter passed");
    end else begin
      $display("tb_autorange_frequency_counter failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/afc_pkg.sv
hdl/afc_cfg.sv
hdl/afc_judge.sv
hdl/afc_core.sv
hdl/autorange_frequency_counter.sv
test/tb_autorange_frequency_counter.sv
